// ----- design/olaru_pkg.sv -----
package olaru_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } state_t;

    typedef struct packed {
        cell_op_t op;
        logic     live;
        logic     is_fill;
        logic     is_tail;
    } cell_ctrl_t;

endpackage

// ----- design/ordered_list_append_remove_unit.sv -----
// Ordered list of signed 32-bit values kept in insertion order.
// Input channel (s_valid/s_ready, s_command, s_value): append, remove first
// equal value, or dump. Result channel (m_valid/m_ready, m_status,
// m_entry_value, m_last, m_entry_count) carries one transfer per append,
// remove or empty dump, and one transfer per entry for a non-empty dump,
// m_last marking the final one. Command code 3 is taken and dropped.
// Append and remove finish in the accepting cycle: every cell compares
// against s_value at once and a found flag ripples down the row, so the
// result sits in the output register in the cycle after the transfer and a
// new item can be taken every cycle while m_ready takes each result at once.
// A dump of N entries enters the dump state, then rotates the row once per
// result through the head cell into the output register, holding while
// m_ready is low; no input is taken meanwhile.
// Reset (aresetn low, synchronous) empties the list and drops any
// pending result. While a result waits with m_ready low, the output register
// holds and s_ready stays low until the result is taken.
module ordered_list_append_remove_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_command,
    input  logic signed [olaru_pkg::VALUE_W-1:0] s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic signed [olaru_pkg::VALUE_W-1:0] m_entry_value,
    output logic                                 m_last,
    output logic [olaru_pkg::COUNT_W-1:0]        m_entry_count
);
    import olaru_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             remain_reg, remain_next;
    logic                      m_valid_reg, m_valid_next;
    status_t                   m_status_reg, m_status_next;
    logic signed [VALUE_W-1:0] m_entry_value_reg, m_entry_value_next;
    logic                      m_last_reg, m_last_next;
    logic [COUNT_W-1:0]        m_entry_count_reg, m_entry_count_next;

    cell_ctrl_t                ctrl [DEPTH];
    cell_op_t                  op;
    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic                      found [DEPTH+1];
    logic                      out_free;
    logic                      accept;
    cmd_t                      cmd;

    assign cmd      = cmd_t'(s_command);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign found[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic signed [VALUE_W-1:0] nxt;
            if (i == DEPTH - 1) begin : g_end
                assign nxt = cell_value[i];
            end else begin : g_mid
                assign nxt = cell_value[i+1];
            end

            assign ctrl[i].op      = op;
            assign ctrl[i].live    = CW'(i) < count_reg;
            assign ctrl[i].is_fill = CW'(i) == count_reg;
            assign ctrl[i].is_tail = CW'(i + 1) == count_reg;

            olaru_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl[i]),
                .din        (s_value),
                .next_value (nxt),
                .head_value (cell_value[0]),
                .found_in   (found[i]),
                .found_out  (found[i+1]),
                .value      (cell_value[i])
            );
        end
    endgenerate

    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        remain_next        = remain_reg;
        op                 = CELL_HOLD;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_entry_value_next = m_entry_value_reg;
        m_last_next        = m_last_reg;
        m_entry_count_next = m_entry_count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_entry_value_next = '0;
                    m_last_next        = 1'b1;
                    unique case (cmd)
                        CMD_APPEND: begin
                            m_valid_next = 1'b1;
                            if (count_reg == CW'(DEPTH)) begin
                                m_status_next = STATUS_FULL;
                            end else begin
                                op            = CELL_LOAD;
                                count_next    = count_reg + 1'b1;
                                m_status_next = STATUS_OK;
                            end
                        end
                        CMD_REMOVE: begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0) begin
                                m_status_next = STATUS_EMPTY;
                            end else if (found[DEPTH]) begin
                                op            = CELL_REMOVE;
                                count_next    = count_reg - 1'b1;
                                m_status_next = STATUS_OK;
                            end else begin
                                m_status_next = STATUS_NOT_FOUND;
                            end
                        end
                        CMD_DUMP: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STATUS_EMPTY;
                            end else begin
                                state_next  = ST_DUMP;
                                remain_next = count_reg;
                            end
                        end
                        default: begin
                            m_last_next = m_last_reg;
                        end
                    endcase
                    m_entry_count_next = COUNT_W'(count_next);
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    op                 = CELL_ROTATE;
                    m_valid_next       = 1'b1;
                    m_status_next      = STATUS_OK;
                    m_entry_value_next = cell_value[0];
                    m_last_next        = remain_reg == CW'(1);
                    m_entry_count_next = COUNT_W'(count_reg);
                    remain_next        = remain_reg - 1'b1;
                    if (remain_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg      <= m_status_next;
        m_entry_value_reg <= m_entry_value_next;
        m_last_reg        <= m_last_next;
        m_entry_count_reg <= m_entry_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_value = m_entry_value_reg;
    assign m_last        = m_last_reg;
    assign m_entry_count = m_entry_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("list count above depth");

    a_no_take_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> !s_ready)
        else $error("input taken during dump");

    a_count_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("count changed without transfer");

    a_full_append_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_APPEND && count_reg == CW'(DEPTH))
        |=> (count_reg == CW'(DEPTH)) && (m_status_reg == STATUS_FULL))
        else $error("append on full list changed state");

    a_dump_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> (remain_reg != '0) && (remain_reg <= count_reg))
        else $error("dump counter out of range");
`endif

endmodule

// ----- design/olaru_cell.sv -----
module olaru_cell (
    input  logic                                aclk,
    input  olaru_pkg::cell_ctrl_t               ctrl,
    input  logic signed [olaru_pkg::VALUE_W-1:0] din,
    input  logic signed [olaru_pkg::VALUE_W-1:0] next_value,
    input  logic signed [olaru_pkg::VALUE_W-1:0] head_value,
    input  logic                                found_in,
    output logic                                found_out,
    output logic signed [olaru_pkg::VALUE_W-1:0] value
);
    import olaru_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      match;

    assign match     = ctrl.live && (value_reg == din);
    assign found_out = found_in || match;
    assign value     = value_reg;

    always_comb begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_LOAD: begin
                if (ctrl.is_fill) begin
                    value_next = din;
                end
            end
            CELL_REMOVE: begin
                if (found_out) begin
                    value_next = next_value;
                end
            end
            CELL_ROTATE: begin
                if (ctrl.is_tail) begin
                    value_next = head_value;
                end else if (ctrl.live) begin
                    value_next = next_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import olaru_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 60;

    typedef struct {
        cmd_t                      command;
        logic signed [VALUE_W-1:0] value;
    } list_command_t;

    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] entry_value;
        logic                      last;
        logic [COUNT_W-1:0]        entry_count;
    } list_result_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_command;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [1:0]                m_status;
    logic signed [VALUE_W-1:0] m_entry_value;
    logic                      m_last;
    logic [COUNT_W-1:0]        m_entry_count;

    list_command_t             pending_commands[$];
    list_result_t              predicted_results[$];
    logic signed [VALUE_W-1:0] model_entries[$];
    list_command_t             offered;

    int   mismatch_count = 0;
    int   accepted_items = 0;
    int   send_wait = 0;
    int   take_wait = 0;
    int   hold_left = 0;
    bit   hold_used = 1'b0;
    bit   send_quiet = 1'b0;
    bit   take_quiet = 1'b0;

    ordered_list_append_remove_unit #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_last        (m_last),
        .m_entry_count (m_entry_count)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    task automatic push_result(status_t st, logic signed [VALUE_W-1:0] v, logic lst);
        list_result_t r;
        r.status      = st;
        r.entry_value = v;
        r.last        = lst;
        r.entry_count = COUNT_W'(model_entries.size());
        predicted_results.push_back(r);
    endtask

    task automatic apply_list_command(cmd_t cmd, logic signed [VALUE_W-1:0] v);
        int idx;
        idx = -1;
        case (cmd)
            CMD_APPEND: begin
                if (model_entries.size() >= LIST_DEPTH) begin
                    push_result(STATUS_FULL, '0, 1'b1);
                end else begin
                    model_entries.push_back(v);
                    push_result(STATUS_OK, '0, 1'b1);
                end
            end
            CMD_REMOVE: begin
                if (model_entries.size() == 0) begin
                    push_result(STATUS_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = model_entries.size() - 1; i >= 0; i--) begin
                        if (model_entries[i] === v) idx = i;
                    end
                    if (idx < 0) begin
                        push_result(STATUS_NOT_FOUND, '0, 1'b1);
                    end else begin
                        model_entries.delete(idx);
                        push_result(STATUS_OK, '0, 1'b1);
                    end
                end
            end
            CMD_DUMP: begin
                if (model_entries.size() == 0) begin
                    push_result(STATUS_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < model_entries.size(); i++) begin
                        push_result(STATUS_OK, model_entries[i],
                                    i == model_entries.size() - 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_command(cmd_t cmd, logic signed [VALUE_W-1:0] v);
        list_command_t c;
        c.command = cmd;
        c.value   = v;
        pending_commands.push_back(c);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_list_command(offered.command, offered.value);
                accepted_items <= accepted_items + 1;
                if ($urandom_range(0, 9) == 0) send_quiet = !send_quiet;
                send_wait = send_quiet ? 0 : $urandom_range(0, 13);
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_commands.size() != 0) begin
                    offered = pending_commands.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= offered.command;
                    s_value   <= offered.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_used && accepted_items >= HOLD_AFTER) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        list_result_t exp_r;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer status=%0d value=%0d",
                                              m_status, m_entry_value));
                end else begin
                    exp_r = predicted_results.pop_front();
                    if (m_status !== exp_r.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                                                  m_status, exp_r.status));
                    if (m_entry_value !== exp_r.entry_value)
                        report_mismatch($sformatf("entry_value got %0d exp %0d",
                                                  m_entry_value, exp_r.entry_value));
                    if (m_last !== exp_r.last)
                        report_mismatch($sformatf("last got %0b exp %0b",
                                                  m_last, exp_r.last));
                    if (m_entry_count !== exp_r.entry_count)
                        report_mismatch($sformatf("entry_count got %0d exp %0d",
                                                  m_entry_count, exp_r.entry_count));
                end
                if ($urandom_range(0, 9) == 0) take_quiet = !take_quiet;
                take_wait = take_quiet ? 0 : $urandom_range(0, 13);
            end
            if (take_wait != 0) begin
                take_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (hold_left == 0);
            end
        end
    end

    initial begin
        logic signed [VALUE_W-1:0] value_pool[6];
        logic signed [VALUE_W-1:0] tail_value;
        logic signed [VALUE_W-1:0] v;
        int  useful;
        int  pick;
        bit  grow;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_command = CMD_NONE;
        s_value   = '0;
        m_ready   = 1'b0;

        queue_command(CMD_DUMP, 0);
        queue_command(CMD_REMOVE, 7);
        queue_command(CMD_APPEND, 32'sh7fff_ffff);
        queue_command(CMD_APPEND, 32'sh8000_0000);
        queue_command(CMD_APPEND, 0);
        queue_command(CMD_APPEND, -1);
        queue_command(CMD_APPEND, 32'sh8000_0000);
        queue_command(CMD_REMOVE, 1234);
        queue_command(CMD_REMOVE, 32'sh8000_0000);
        queue_command(CMD_DUMP, 0);
        queue_command(CMD_REMOVE, 32'sh7fff_ffff);
        tail_value = 0;
        for (int i = 0; i < 13; i++) begin
            tail_value = $urandom;
            queue_command(CMD_APPEND, tail_value);
        end
        queue_command(CMD_APPEND, 5);
        queue_command(CMD_DUMP, 32'sh7fff_ffff);
        queue_command(CMD_REMOVE, tail_value);
        queue_command(CMD_NONE, $urandom);

        value_pool[0] = 32'sh7fff_ffff;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 0;
        value_pool[3] = -1;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom;
        useful = 0;
        grow   = 1'b1;
        while (useful < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) grow = !grow;
            pick = $urandom_range(0, 99);
            v = ($urandom_range(0, 7) == 0) ? $urandom : value_pool[$urandom_range(0, 5)];
            if (pick < 3) begin
                queue_command(CMD_NONE, v);
            end else begin
                if (pick < 13)
                    queue_command(CMD_DUMP, v);
                else if (pick < (grow ? 75 : 40))
                    queue_command(CMD_APPEND, v);
                else
                    queue_command(CMD_REMOVE, v);
                useful++;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_commands.size() != 0 || s_valid) @(posedge aclk);
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (LIST_DEPTH + 4) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
